/* src/isc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the insertion sorter.
// No dependencies; imported by isc_cell and insertion_sorter.
package isc_pkg;

   localparam int VALUE_BITS = 32;

   typedef enum logic {
      ST_FILL,
      ST_DRAIN
   } sorter_state_type;

   typedef struct packed {
      logic insert;
      logic drain;
   } chain_ctl_type;

endpackage

/* src/isc_cell.sv */
`timescale 1ns / 1ps
// One cell of the insertion chain: holds one entry and its valid bit.
// Depends on isc_pkg for the chain control struct.
module isc_cell #(
   parameter int ELEMENT_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  isc_pkg::chain_ctl_type    ctl,
   input  logic [ELEMENT_BITS-1:0]   new_value,
   input  logic                      left_valid,
   input  logic                      left_gt,
   input  logic [ELEMENT_BITS-1:0]   left_value,
   input  logic                      right_valid,
   input  logic [ELEMENT_BITS-1:0]   right_value,
   output logic                      cell_valid,
   output logic                      cell_gt,
   output logic [ELEMENT_BITS-1:0]   cell_value
);
   import isc_pkg::*;

   logic                    valid_ff;
   logic                    valid_in;
   logic [ELEMENT_BITS-1:0] value_ff;
   logic [ELEMENT_BITS-1:0] value_in;

   assign cell_valid = valid_ff;
   assign cell_value = value_ff;
   assign cell_gt    = valid_ff && ($signed(new_value) < $signed(value_ff));

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.drain) begin
         valid_in = right_valid;
         value_in = right_value;
      end else if (ctl.insert) begin
         if (left_gt) begin
            valid_in = 1'b1;
            value_in = left_value;
         end else if (cell_gt) begin
            value_in = new_value;
         end else if (!valid_ff && left_valid) begin
            valid_in = 1'b1;
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

endmodule

/* src/insertion_sorter.sv */
`timescale 1ns / 1ps
// Top level of the insertion sorter: a row of isc_cell instances and the run controller.
// Depends on isc_pkg and isc_cell.
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  req_value, req_end_of_run
//   rsp       out         rsp_valid/rsp_stall  rsp_sorted_value, rsp_final_result,
//                                              rsp_overflowed
//
// While a run is filling, one beat is taken every cycle; each cell compares the new value
// with its entry and the row shifts larger entries one place up in that same cycle.
// A beat marked end of run turns the block to draining: the run of N entries leaves in N
// beats from the head cell, one per cycle when rsp_stall is low, and req_stall is high
// until the last result is taken. rsp_stall only holds the row, it loses nothing.
// Reset clears every valid bit and the overflow flag; entry data needs no reset.
module insertion_sorter #(
   parameter int CAPACITY     = 64,
   parameter int ELEMENT_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [isc_pkg::VALUE_BITS-1:0] req_value,
   input  logic                                req_end_of_run,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [isc_pkg::VALUE_BITS-1:0] rsp_sorted_value,
   output logic                                rsp_final_result,
   output logic                                rsp_overflowed
);
   import isc_pkg::*;

   sorter_state_type        state_ff;
   sorter_state_type        state_in;
   logic                    dropped_ff;
   logic                    dropped_in;
   chain_ctl_type           ctl;
   logic                    req_fire;
   logic                    rsp_fire;
   logic                    chain_full;
   logic                    last_entry;
   logic [ELEMENT_BITS-1:0] new_value;

   logic                    cell_valid [CAPACITY];
   logic                    cell_gt    [CAPACITY];
   logic [ELEMENT_BITS-1:0] cell_value [CAPACITY];

   assign new_value = ELEMENT_BITS'($unsigned(req_value));

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    left_valid;
      logic                    left_gt;
      logic [ELEMENT_BITS-1:0] left_value;
      logic                    right_valid;
      logic [ELEMENT_BITS-1:0] right_value;

      if (i == 0) begin : g_head
         assign left_valid = 1'b1;
         assign left_gt    = 1'b0;
         assign left_value = '0;
      end else begin : g_body
         assign left_valid = cell_valid[i-1];
         assign left_gt    = cell_gt[i-1];
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_value = '0;
      end else begin : g_inner
         assign right_valid = cell_valid[i+1];
         assign right_value = cell_value[i+1];
      end

      isc_cell #(
         .ELEMENT_BITS(ELEMENT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_value  (new_value),
         .left_valid (left_valid),
         .left_gt    (left_gt),
         .left_value (left_value),
         .right_valid(right_valid),
         .right_value(right_value),
         .cell_valid (cell_valid[i]),
         .cell_gt    (cell_gt[i]),
         .cell_value (cell_value[i])
      );
   end

   assign chain_full = cell_valid[CAPACITY-1];
   assign last_entry = !cell_valid[1];

   assign rsp_sorted_value = VALUE_BITS'($signed(cell_value[0]));
   assign rsp_final_result = last_entry;
   assign rsp_overflowed   = dropped_ff;

   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      req_stall  = 1'b0;
      rsp_valid  = 1'b0;
      req_fire   = 1'b0;
      rsp_fire   = 1'b0;
      ctl        = '0;
      case (state_ff)
         ST_FILL: begin
            req_fire   = req_valid;
            ctl.insert = req_fire && !chain_full;
            if (req_fire && chain_full) begin
               dropped_in = 1'b1;
            end
            if (req_fire && req_end_of_run) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            req_stall = 1'b1;
            rsp_valid = 1'b1;
            rsp_fire  = !rsp_stall;
            ctl.drain = rsp_fire;
            if (rsp_fire && last_entry) begin
               dropped_in = 1'b0;
               state_in   = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

   a_drain_not_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> cell_valid[0])
      else $error("draining with an empty head cell");

   a_drop_sets_flag: assert property (@(posedge clock) disable iff (reset)
      req_fire && chain_full |=> dropped_ff)
      else $error("dropped value did not raise the overflow flag");

   a_run_done_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && last_entry |=> state_ff == ST_FILL && !cell_valid[0] && !dropped_ff)
      else $error("row not empty after the final result");

   a_drain_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !last_entry |=> rsp_valid)
      else $error("drain stopped before the final result");

endmodule

/* tb/sv/insertion_sorter_checker.sv */
`timescale 1ns / 1ps
// Checker for the insertion sorter: watches both channels, predicts every sorted run and
// compares each result beat with it. Depends on isc_pkg for the value width.
module insertion_sorter_checker #(
   parameter int CAPACITY = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [isc_pkg::VALUE_BITS-1:0] req_value,
   input  logic                                 req_end_of_run,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [isc_pkg::VALUE_BITS-1:0] rsp_sorted_value,
   input  logic                                 rsp_final_result,
   input  logic                                 rsp_overflowed,
   output int                                   mismatch_count,
   output int                                   results_due
);

   localparam int VB = isc_pkg::VALUE_BITS;

   typedef struct packed {
      logic signed [VB-1:0] value;
      logic                 last;
      logic                 overflow;
   } sorted_beat_type;

   logic signed [VB-1:0] run_store [CAPACITY];
   int                   held;
   bit                   spilled;
   sorted_beat_type      sorted_due [$];
   int                   mismatches;

   task automatic report_mismatch(input string what, input logic [VB-1:0] got,
                                  input logic [VB-1:0] want);
      mismatches++;
      $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // A new value is placed above every entry that is not strictly greater, so that equal
   // values stay in arrival order.
   task automatic absorb_value(input logic signed [VB-1:0] v);
      int pos;
      if (held >= CAPACITY) begin
         spilled = 1'b1;
      end else begin
         pos = held;
         while (pos > 0 && v < run_store[pos-1]) begin
            run_store[pos] = run_store[pos-1];
            pos--;
         end
         run_store[pos] = v;
         held++;
      end
   endtask

   task automatic release_run();
      for (int k = 0; k < held; k++) begin
         sorted_due.push_back('{run_store[k], (k == held - 1), spilled});
      end
      held = 0;
      spilled = 1'b0;
   endtask

   always @(posedge clock) begin : track
      sorted_beat_type due;
      if (reset) begin
         held = 0;
         spilled = 1'b0;
         sorted_due.delete();
         mismatches = 0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_value(req_value);
            if (req_end_of_run) begin
               release_run();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (sorted_due.size() == 0) begin
               report_mismatch("result beat with nothing expected", rsp_sorted_value, '0);
            end else begin
               due = sorted_due.pop_front();
               if (rsp_sorted_value !== due.value) begin
                  report_mismatch("sorted_value", rsp_sorted_value, due.value);
               end
               if (rsp_final_result !== due.last) begin
                  report_mismatch("final_result", rsp_final_result, due.last);
               end
               if (rsp_overflowed !== due.overflow) begin
                  report_mismatch("overflowed", rsp_overflowed, due.overflow);
               end
            end
         end
      end
      mismatch_count <= mismatches;
      results_due <= sorted_due.size();
   end

endmodule

/* tb/sv/tb_insertion_sorter.sv */
`timescale 1ns / 1ps
// Top of the insertion sorter testbench: clock, reset, run stimulus and result pacing.
// Depends on isc_pkg, insertion_sorter and insertion_sorter_checker.
module tb_insertion_sorter;

   localparam int VB           = isc_pkg::VALUE_BITS;
   localparam int CAPACITY     = 64;
   localparam int ELEMENT_BITS = 32;
   localparam int RANDOM_ITEMS = 160;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_SLACK  = 20;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic signed [VB-1:0] req_value = '0;
   logic          req_end_of_run = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic signed [VB-1:0] rsp_sorted_value;
   logic          rsp_final_result;
   logic          rsp_overflowed;
   int            mismatch_count;
   int            results_due;
   bit            squeeze_armed = 1'b0;
   bit            squeeze_done = 1'b0;

   always #1 clock = ~clock;

   insertion_sorter #(
      .CAPACITY     (CAPACITY),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_end_of_run   (req_end_of_run),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_result (rsp_final_result),
      .rsp_overflowed   (rsp_overflowed)
   );

   insertion_sorter_checker #(
      .CAPACITY (CAPACITY)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_end_of_run   (req_end_of_run),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_result (rsp_final_result),
      .rsp_overflowed   (rsp_overflowed),
      .mismatch_count   (mismatch_count),
      .results_due      (results_due)
   );

   function automatic int draw_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [VB-1:0] draw_value();
      int pick;
      pick = $urandom_range(0, 11);
      case (pick)
         0: return {1'b1, {(VB-1){1'b0}}};
         1: return {1'b0, {(VB-1){1'b1}}};
         2: return '0;
         3: return '1;
         4, 5, 6: return $urandom_range(0, 8) - 4;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_beat(input logic signed [VB-1:0] v, input logic eor, input bit steady);
      int gap;
      req_valid <= 1'b1;
      req_value <= v;
      req_end_of_run <= eor;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = steady ? 0 : draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Result pacing. Once armed, the first draining run is held off for a long stretch while
   // the sender keeps offering the next beat.
   initial begin : rsp_pacing
      int span;
      int kind;
      while (reset) @(posedge clock);
      forever begin
         kind = $urandom_range(0, 9);
         if (squeeze_armed && !squeeze_done) kind = 0;
         if (kind < 5) begin
            span = $urandom_range(1, 24);
            for (int k = 0; k < span; k++) begin
               if (squeeze_armed && !squeeze_done && rsp_valid) begin
                  squeeze_done = 1'b1;
                  rsp_stall <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
               end else begin
                  rsp_stall <= 1'b0;
                  @(posedge clock);
               end
            end
         end else begin
            rsp_stall <= 1'b1;
            span = (kind == 9) ? $urandom_range(12, 40) : $urandom_range(1, 3);
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("tb_insertion_sorter NOT OK");
      $finish;
   end

   initial begin : stimulus
      int   random_items;
      int   run_idx;
      int   run_len;
      bit   steady;
      logic signed [VB-1:0] lowest;
      logic signed [VB-1:0] highest;
      lowest = {1'b1, {(VB-1){1'b0}}};
      highest = {1'b0, {(VB-1){1'b1}}};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // A run of one beat, then the extremes mixed with values around zero.
      send_beat(0, 1'b1, 1'b0);
      send_beat(highest, 1'b0, 1'b1);
      send_beat(lowest, 1'b0, 1'b1);
      send_beat(-1, 1'b0, 1'b0);
      send_beat(1, 1'b0, 1'b0);
      send_beat(0, 1'b1, 1'b0);
      // A descending run and a run with repeated values.
      for (int k = 5; k >= 1; k--) send_beat(k, k == 1, 1'b1);
      send_beat(7, 1'b0, 1'b0);
      send_beat(-7, 1'b0, 1'b0);
      send_beat(7, 1'b0, 1'b0);
      send_beat(7, 1'b0, 1'b0);
      send_beat(-7, 1'b1, 1'b0);
      send_beat(lowest, 1'b1, 1'b1);
      send_beat(highest, 1'b1, 1'b1);
      send_beat(highest, 1'b0, 1'b0);
      send_beat(highest, 1'b1, 1'b0);

      squeeze_armed = 1'b1;
      random_items = 0;
      run_idx = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (run_idx == 3) run_len = CAPACITY;
         else if (run_idx == 7) run_len = CAPACITY + 3;
         else if ($urandom_range(0, 11) == 0) run_len = $urandom_range(11, CAPACITY + 2);
         else run_len = $urandom_range(1, 10);
         steady = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < run_len; k++) begin
            send_beat(draw_value(), k == run_len - 1, steady);
         end
         random_items += run_len;
         run_idx++;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_insertion_sorter OK");
      end else begin
         $display("tb_insertion_sorter NOT OK");
      end
      $finish;
   end

endmodule
